// File: hw/rtl/rtdc_pkg.sv
// Shared types and constants for the RTD code to temperature converter.
// Standalone package; used by rtd_code_to_temperature.
`default_nettype none

package rtdc_pkg;

    localparam int RAW_W     = 16;
    localparam int CODE_W    = 15;
    localparam int OHM_W     = 21;
    localparam int TEMP_W    = 19;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL   = 2'd1;

    localparam logic [OHM_W-1:0] REF_RESET = 21'd102400;
    localparam logic [OHM_W-1:0] NOM_RESET = 21'd25600;

    // divider: 60-bit dividend, 39 quotient bits
    localparam int DIV_W = 60;
    localparam int QUO_W = 39;

    // Callendar-Van Dusen in integer form: D = A*1e10, K = -B*1e10
    localparam logic [25:0] CVD_D   = 26'd39083000;
    localparam logic [12:0] CVD_K   = 13'd5775;
    localparam logic [51:0] CVD_D2  = 52'(64'd39083000 * 64'd39083000);
    localparam logic [QUO_W-1:0] Q_LIMIT =
        QUO_W'((64'd39083000 * 64'd39083000) / 64'd5775);
    // 4e10 = 39062500 * 2^10
    localparam logic [25:0] SCALE_4E10 = 26'd39062500;

    localparam int SQ_W     = 52;
    localparam int SQ_STEPS = 26;

    localparam logic [13:0] DIV_11550   = 14'd11550;
    localparam int          RECIP_SHIFT = 35;
    localparam logic [21:0] RECIP_11550 = 22'((64'd1 << 35) / 64'd11550);

    typedef logic signed [35:0] acc_t;

    // c_i * 100^i in Q24, rounded to nearest
    localparam acc_t POLY_Q24 [6] = '{
        36'(-((64'sd24202 * 64'sd16777216 + 64'sd50) / 64'sd100)),
        36'((64'sd22228 * 64'sd16777216 + 64'sd50) / 64'sd100),
        36'((64'sd25859 * 64'sd16777216 + 64'sd500) / 64'sd1000),
        36'(-((64'sd48260 * 64'sd16777216 + 64'sd5000) / 64'sd10000)),
        36'(-((64'sd28183 * 64'sd16777216 + 64'sd5000) / 64'sd10000)),
        36'((64'sd15243 * 64'sd16777216 + 64'sd5000) / 64'sd10000)
    };

    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 19'sd262143;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -19'sd65536;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              fault;
        logic [OHM_W-1:0]  res;
        logic              ge;
        logic              sat;
    } side_t;

endpackage

`default_nettype wire

// File: hw/rtl/rtd_code_to_temperature.sv
// RTD converter word to resistance and temperature, fully pipelined.
// Depends on rtdc_pkg.
//
// Usage:
//   s_valid/s_ready/s_raw_word carry one converter word per transaction;
//   m_valid/m_ready and the m_ fields carry one result per word, in order.
//   cfg_wr_en/cfg_index/cfg_wr_data write the reference (index 0) and nominal
//   (index 1) resistances; write only while the pipeline is empty.
// Throughput: one transaction per cycle while the output does not stall. Most
//   of the pipeline depth comes from the 39-stage restoring divider (one
//   quotient bit per stage) and the 26-stage square root (one root bit per
//   stage); the polynomial branch runs beside the square root.
// Reset (aresetn low, synchronous) empties the pipeline and restores the
//   register defaults.
// Stall: every stage advances together; when m_valid is high and m_ready is
//   low the whole pipeline holds and s_ready drops, nothing is lost.
`default_nettype none

module rtd_code_to_temperature (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [rtdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rtdc_pkg::OHM_W-1:0]      cfg_wr_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [rtdc_pkg::RAW_W-1:0]      s_raw_word,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [rtdc_pkg::CODE_W-1:0]          m_adc_code,
    output logic                                 m_fault_flag,
    output logic [rtdc_pkg::OHM_W-1:0]           m_resistance_q8,
    output logic signed [rtdc_pkg::TEMP_W-1:0]   m_temperature_q8
);

    import rtdc_pkg::*;

    localparam int DIV_LAST = QUO_W;
    localparam int Q1_IDX   = DIV_LAST + 1;
    localparam int Q2_IDX   = DIV_LAST + 2;
    localparam int SQ_FIRST = Q2_IDX + 1;
    localparam int F1_IDX   = SQ_FIRST + SQ_STEPS;
    localparam int LAST_IDX = F1_IDX + 2;
    localparam int H_STEPS  = 5;
    localparam int PT_DELAY = LAST_IDX - (DIV_LAST + 2 * H_STEPS + 1);

    // configuration
    logic [OHM_W-1:0] ref_reg;
    logic [OHM_W-1:0] nom_reg;
    logic [OHM_W-1:0] r0e;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg <= REF_RESET;
            nom_reg <= NOM_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_REFERENCE: ref_reg <= cfg_wr_data;
                CFG_NOMINAL:   nom_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign r0e = (nom_reg == '0) ? OHM_W'(1) : nom_reg;

    logic en;
    logic m_valid_reg;
    assign en      = ~m_valid_reg | m_ready;
    assign s_ready = en;

    // stage A: resistance product
    logic              a_vld_reg;
    logic [CODE_W-1:0] a_code_reg;
    logic              a_fault_reg;
    logic [35:0]       a_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) a_vld_reg <= 1'b0;
        else if (en)  a_vld_reg <= s_valid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_code_reg  <= s_raw_word[RAW_W-1:1];
            a_fault_reg <= s_raw_word[0];
            a_prod_reg  <= 36'(s_raw_word[RAW_W-1:1]) * 36'(ref_reg);
        end
    end

    // stage B: branch select and scaled difference
    logic              b_vld_reg;
    logic [CODE_W-1:0] b_code_reg;
    logic              b_fault_reg;
    logic [OHM_W-1:0]  b_res_reg;
    logic              b_ge_reg;
    logic [46:0]       b_dm_reg;
    logic [OHM_W-1:0]  b_res_next;
    logic [OHM_W-1:0]  b_diff;

    assign b_res_next = a_prod_reg[35:15];
    assign b_diff     = b_res_next - r0e;

    always_ff @(posedge aclk) begin
        if (!aresetn) b_vld_reg <= 1'b0;
        else if (en)  b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_code_reg  <= a_code_reg;
            b_fault_reg <= a_fault_reg;
            b_res_reg   <= b_res_next;
            b_ge_reg    <= (b_res_next >= r0e);
            b_dm_reg    <= 47'(b_diff) * 47'(SCALE_4E10);
        end
    end

    // side data travels with every stage from the divider load onward
    logic  vld_reg  [0:LAST_IDX];
    side_t side_reg [0:LAST_IDX];

    logic [DIV_W-1:0] rem_reg [0:DIV_LAST];
    logic [QUO_W-1:0] quo_reg [0:DIV_LAST];

    logic [DIV_W-1:0] c_num;
    logic             c_ovf;

    assign c_num = b_ge_reg ? {3'b0, b_dm_reg, 10'b0} : {15'b0, b_res_reg, 24'b0};
    // quotient would not fit in QUO_W bits
    assign c_ovf = b_ge_reg & (c_num[DIV_W-1:QUO_W] >= r0e);

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg[0] <= 1'b0;
        else if (en)  vld_reg[0] <= b_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= '{code: b_code_reg, fault: b_fault_reg, res: b_res_reg,
                             ge: b_ge_reg, sat: c_ovf};
            rem_reg[0]  <= c_num;
            quo_reg[0]  <= '0;
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 1; k <= DIV_LAST; k++) begin : g_div
        logic [DIV_W-1:0] dsh;
        logic             take;
        assign dsh  = DIV_W'(r0e) << (QUO_W - k);
        assign take = (rem_reg[k-1] >= dsh);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= take ? (rem_reg[k-1] - dsh) : rem_reg[k-1];
                quo_reg[k] <= quo_reg[k-1] | (QUO_W'(take) << (QUO_W - k));
            end
        end
    end

    logic q_gt;
    assign q_gt = (quo_reg[DIV_LAST] > Q_LIMIT);

    for (genvar i = 1; i <= LAST_IDX; i++) begin : g_side
        always_ff @(posedge aclk) begin
            if (!aresetn) vld_reg[i] <= 1'b0;
            else if (en)  vld_reg[i] <= vld_reg[i-1];
        end

        if (i == Q1_IDX) begin : g_sat
            always_ff @(posedge aclk) begin
                if (en) begin
                    side_reg[i] <= '{code: side_reg[i-1].code, fault: side_reg[i-1].fault,
                                     res: side_reg[i-1].res, ge: side_reg[i-1].ge,
                                     sat: side_reg[i-1].sat | q_gt};
                end
            end
        end else begin : g_pass
            always_ff @(posedge aclk) begin
                if (en) side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // quadratic branch: E = D^2 - K*q
    logic [51:0]     q1_qk_reg;
    logic [SQ_W-1:0] q2_e_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            q1_qk_reg <= 52'(quo_reg[DIV_LAST]) * 52'(CVD_K);
            q2_e_reg  <= CVD_D2 - q1_qk_reg;
        end
    end

    // integer square root, one root bit per stage
    logic [SQ_W-1:0] sqx_reg [0:SQ_STEPS-1];
    logic [SQ_W-1:0] sqr_reg [0:SQ_STEPS-1];

    for (genvar n = 0; n < SQ_STEPS; n++) begin : g_sqrt
        logic [SQ_W-1:0] x_in;
        logic [SQ_W-1:0] r_in;
        logic [SQ_W-1:0] trial;
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - n));

        if (n == 0) begin : g_first
            assign x_in = q2_e_reg;
            assign r_in = '0;
        end else begin : g_next
            assign x_in = sqx_reg[n-1];
            assign r_in = sqr_reg[n-1];
        end

        assign trial = r_in + BIT;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (x_in >= trial) begin
                    sqx_reg[n] <= x_in - trial;
                    sqr_reg[n] <= (r_in >> 1) + BIT;
                end else begin
                    sqx_reg[n] <= x_in;
                    sqr_reg[n] <= r_in >> 1;
                end
            end
        end
    end

    // ((D - s) * 256 + K) / 11550 by reciprocal and one correction
    logic [33:0] f1_num_reg;
    logic [33:0] f2_num_reg;
    logic [55:0] f2_pm_reg;
    logic [20:0] f3_qe_reg;
    logic [34:0] f3_rem_reg;
    logic [20:0] f3_qe_next;

    assign f3_qe_next = f2_pm_reg[55:RECIP_SHIFT];

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_num_reg <= {CVD_D - sqr_reg[SQ_STEPS-1][25:0], 8'b0} + 34'(CVD_K);
            f2_num_reg <= f1_num_reg;
            f2_pm_reg  <= 56'(f1_num_reg) * 56'(RECIP_11550);
            f3_qe_reg  <= f3_qe_next;
            f3_rem_reg <= 35'(f2_num_reg) - 35'(f3_qe_next) * 35'(DIV_11550);
        end
    end

    // polynomial branch: Horner in Q24, products truncated toward zero
    logic signed [60:0] hp_reg   [0:H_STEPS-1];
    acc_t               hacc_reg [0:H_STEPS-1];
    logic [23:0]        hvm_reg  [0:H_STEPS-1];
    logic [23:0]        hva_reg  [0:H_STEPS-1];

    for (genvar h = 0; h < H_STEPS; h++) begin : g_horner
        acc_t               acc_in;
        logic [23:0]        v_in;
        logic signed [60:0] trunc;

        if (h == 0) begin : g_first
            assign acc_in = POLY_Q24[H_STEPS];
            assign v_in   = quo_reg[DIV_LAST][23:0];
        end else begin : g_next
            assign acc_in = hacc_reg[h-1];
            assign v_in   = hva_reg[h-1];
        end

        assign trunc = (hp_reg[h] < 0) ? ((hp_reg[h] + 61'sd16777215) >>> 24)
                                        : (hp_reg[h] >>> 24);

        always_ff @(posedge aclk) begin
            if (en) begin
                hp_reg[h]   <= acc_in * $signed({1'b0, v_in});
                hvm_reg[h]  <= v_in;
                hacc_reg[h] <= POLY_Q24[H_STEPS-1-h] + $signed(trunc[35:0]);
                hva_reg[h]  <= hvm_reg[h];
            end
        end
    end

    logic signed [36:0]       rnd_full;
    logic signed [20:0]       rnd;
    logic signed [TEMP_W-1:0] pt_next;
    logic signed [TEMP_W-1:0] pt_reg [0:PT_DELAY];

    assign rnd_full = (37'(hacc_reg[H_STEPS-1]) + 37'sd32768) >>> 16;
    assign rnd      = $signed(rnd_full[20:0]);

    always_comb begin
        priority if (rnd > 21'(TEMP_MAX)) pt_next = TEMP_MAX;
        else if (rnd < 21'(TEMP_MIN))     pt_next = TEMP_MIN;
        else                              pt_next = rnd[TEMP_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) pt_reg[0] <= pt_next;
    end

    for (genvar p = 1; p <= PT_DELAY; p++) begin : g_pt
        always_ff @(posedge aclk) begin
            if (en) pt_reg[p] <= pt_reg[p-1];
        end
    end

    // output stage
    logic [21:0]              tq;
    logic signed [TEMP_W-1:0] quad_t;
    logic signed [TEMP_W-1:0] temp_next;
    side_t                    fin;

    assign fin    = side_reg[LAST_IDX];
    assign tq     = 22'(f3_qe_reg) + 22'(f3_rem_reg >= 35'(DIV_11550));
    assign quad_t = (tq > 22'(TEMP_MAX)) ? TEMP_MAX : $signed(tq[TEMP_W-1:0]);

    always_comb begin
        priority if (fin.sat) temp_next = TEMP_MAX;
        else if (fin.ge)      temp_next = quad_t;
        else                  temp_next = pt_reg[PT_DELAY];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (en)  m_valid_reg <= vld_reg[LAST_IDX];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_adc_code       <= fin.code;
            m_fault_flag     <= fin.fault;
            m_resistance_q8  <= fin.res;
            m_temperature_q8 <= temp_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire
